@@ design/sdo_dl_pkg.sv @@
// ----------------------------------------------------------------------------
// sdo_dl_pkg
// Types and constants shared by the SDO segmented download client.
// ----------------------------------------------------------------------------
package sdo_dl_pkg;

	typedef enum logic [1:0] {
		OP_START,
		OP_DATA,
		OP_REPLY,
		OP_ERROR
	} op_t;

	typedef enum logic [1:0] {
		KIND_FRAME,
		KIND_DONE,
		KIND_FAIL
	} kind_t;

	typedef enum logic [2:0] {
		CAUSE_NONE,
		CAUSE_TRANSPORT,
		CAUSE_REPLY_ID,
		CAUSE_INDEX,
		CAUSE_SUBINDEX,
		CAUSE_COMMAND,
		CAUSE_UNEXPECTED
	} cause_t;

	localparam logic [10:0] TX_BASE      = 11'h600;
	localparam logic [10:0] RX_BASE      = 11'h580;
	localparam logic [7:0]  CMD_INITIATE = 8'h20;
	localparam logic [7:0]  CMD_INIT_ACK = 8'h60;
	localparam logic [7:0]  CMD_SEG_ACK  = 8'h20;
	localparam logic [7:0]  TOGGLE_MASK  = 8'h10;
	localparam logic        LAST_FLAG    = 1'b1;
	localparam logic [2:0]  SEG_BYTES    = 3'd7;

	typedef struct packed {
		op_t         op;
		logic [15:0] object_index;
		logic [7:0]  object_subindex;
		logic [15:0] total_size;
		logic [7:0]  data_byte;
		logic [10:0] reply_id;
		logic [7:0]  reply_command;
		logic [15:0] reply_index;
		logic [7:0]  reply_subindex;
	} item_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [10:0] frame_id;
		logic [63:0] frame_bytes;
		cause_t      cause;
	} result_t;

endpackage

@@ design/sdo_dl_engine.sv @@
// ----------------------------------------------------------------------------
// sdo_dl_engine
// Transfer state and one-item step logic: builds initiate and segment
// frames, checks replies, reports finish or failure.
// ----------------------------------------------------------------------------
module sdo_dl_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  sdo_dl_pkg::item_t  item,
	input  logic [6:0]         node_id,
	output sdo_dl_pkg::result_t res
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_INIT_WAIT,
		PH_GATHER,
		PH_SEG_WAIT
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        toggle_q, toggle_d;
	logic [15:0] left_q, left_d;
	logic [55:0] store_q, store_d;
	logic [2:0]  fill_q, fill_d;
	logic [15:0] idx_q, idx_d;
	logic [7:0]  sub_q, sub_d;
	logic        last_q, last_d;
	logic        do_clear;

	logic [10:0] tx_id;
	logic [10:0] rx_id;
	logic [55:0] store_ins;
	logic [2:0]  fill_inc;
	logic [15:0] left_dec;
	logic        seg_last;
	logic [7:0]  seg_cmd;
	logic [7:0]  ack_cmd;

	assign tx_id    = sdo_dl_pkg::TX_BASE + {4'b0, node_id};
	assign rx_id    = sdo_dl_pkg::RX_BASE + {4'b0, node_id};
	assign fill_inc = fill_q + 3'd1;
	assign left_dec = left_q - 16'd1;
	assign seg_last = (left_dec == 16'd0);
	assign seg_cmd  = {3'b000, toggle_q, sdo_dl_pkg::SEG_BYTES - fill_inc,
		seg_last & sdo_dl_pkg::LAST_FLAG};
	assign ack_cmd  = sdo_dl_pkg::CMD_SEG_ACK | (toggle_q ? sdo_dl_pkg::TOGGLE_MASK : 8'h00);

	// drop the new byte into the lane picked by the fill count
	always_comb begin
		store_ins = store_q;
		for (int i = 0; i < 7; i++) begin
			if (fill_q == 3'(i))
				store_ins[8*i +: 8] = store_q[8*i +: 8] | item.data_byte;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		toggle_d = toggle_q;
		left_d   = left_q;
		store_d  = store_q;
		fill_d   = fill_q;
		idx_d    = idx_q;
		sub_d    = sub_q;
		last_d   = last_q;
		do_clear = 1'b0;
		res      = '0;

		if (phase_q == PH_IDLE) begin
			if (item.op == sdo_dl_pkg::OP_START) begin
				phase_d  = PH_INIT_WAIT;
				toggle_d = 1'b0;
				left_d   = item.total_size;
				store_d  = '0;
				fill_d   = '0;
				idx_d    = item.object_index;
				sub_d    = item.object_subindex;
				last_d   = 1'b0;
				res.valid       = 1'b1;
				res.kind        = sdo_dl_pkg::KIND_FRAME;
				res.frame_id    = tx_id;
				res.frame_bytes = {32'h0, item.object_subindex, item.object_index,
					sdo_dl_pkg::CMD_INITIATE};
			end
		end else begin
			case (item.op)
				sdo_dl_pkg::OP_START: begin
					do_clear  = 1'b1;
					res.valid = 1'b1;
					res.kind  = sdo_dl_pkg::KIND_FAIL;
					res.cause = sdo_dl_pkg::CAUSE_UNEXPECTED;
				end
				sdo_dl_pkg::OP_ERROR: begin
					do_clear  = 1'b1;
					res.valid = 1'b1;
					res.kind  = sdo_dl_pkg::KIND_FAIL;
					res.cause = sdo_dl_pkg::CAUSE_TRANSPORT;
				end
				sdo_dl_pkg::OP_DATA: begin
					if (phase_q != PH_GATHER) begin
						do_clear  = 1'b1;
						res.valid = 1'b1;
						res.kind  = sdo_dl_pkg::KIND_FAIL;
						res.cause = sdo_dl_pkg::CAUSE_UNEXPECTED;
					end else begin
						store_d = store_ins;
						fill_d  = fill_inc;
						left_d  = left_dec;
						if (fill_inc == sdo_dl_pkg::SEG_BYTES || seg_last) begin
							last_d          = seg_last;
							phase_d         = PH_SEG_WAIT;
							res.valid       = 1'b1;
							res.kind        = sdo_dl_pkg::KIND_FRAME;
							res.frame_id    = tx_id;
							res.frame_bytes = {store_ins, seg_cmd};
						end
					end
				end
				sdo_dl_pkg::OP_REPLY: begin
					res.valid = 1'b1;
					res.kind  = sdo_dl_pkg::KIND_FAIL;
					do_clear  = 1'b1;
					if (phase_q == PH_GATHER)
						res.cause = sdo_dl_pkg::CAUSE_UNEXPECTED;
					else if (item.reply_id != rx_id)
						res.cause = sdo_dl_pkg::CAUSE_REPLY_ID;
					else if (phase_q == PH_INIT_WAIT) begin
						if (item.reply_index != idx_q)
							res.cause = sdo_dl_pkg::CAUSE_INDEX;
						else if (item.reply_subindex != sub_q)
							res.cause = sdo_dl_pkg::CAUSE_SUBINDEX;
						else if (item.reply_command != sdo_dl_pkg::CMD_INIT_ACK)
							res.cause = sdo_dl_pkg::CAUSE_COMMAND;
						else if (left_q == 16'd0)
							res.kind = sdo_dl_pkg::KIND_DONE;
						else begin
							res.valid = 1'b0;
							do_clear  = 1'b0;
							phase_d   = PH_GATHER;
							store_d   = '0;
							fill_d    = '0;
						end
					end else begin
						if (item.reply_command != ack_cmd)
							res.cause = sdo_dl_pkg::CAUSE_COMMAND;
						else if (last_q)
							res.kind = sdo_dl_pkg::KIND_DONE;
						else begin
							res.valid = 1'b0;
							do_clear  = 1'b0;
							toggle_d  = ~toggle_q;
							phase_d   = PH_GATHER;
							store_d   = '0;
							fill_d    = '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			toggle_q <= 1'b0;
			left_q   <= '0;
			store_q  <= '0;
			fill_q   <= '0;
			idx_q    <= '0;
			sub_q    <= '0;
			last_q   <= 1'b0;
		end else if (step) begin
			if (do_clear) begin
				phase_q  <= PH_IDLE;
				toggle_q <= 1'b0;
				left_q   <= '0;
				store_q  <= '0;
				fill_q   <= '0;
				idx_q    <= '0;
				sub_q    <= '0;
				last_q   <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				toggle_q <= toggle_d;
				left_q   <= left_d;
				store_q  <= store_d;
				fill_q   <= fill_d;
				idx_q    <= idx_d;
				sub_q    <= sub_d;
				last_q   <= last_d;
			end
		end
	end

	a_gather_fill: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_GATHER |-> fill_q != sdo_dl_pkg::SEG_BYTES)
		else $error("segment fill overran while gathering");

	a_gather_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_GATHER |-> left_q != 16'd0)
		else $error("gathering with no bytes left");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> (!toggle_q && !last_q && fill_q == 3'd0))
		else $error("idle with stale transfer state");

	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.valid && res.kind != sdo_dl_pkg::KIND_FRAME) |=> phase_q == PH_IDLE)
		else $error("finish or failure did not return to idle");

endmodule

@@ design/sdo_segmented_download_client_core.sv @@
// ----------------------------------------------------------------------------
// sdo_segmented_download_client_core
// Client side of a CANopen SDO segmented download.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis stream: tuser carries the op (start, data
// byte, reply frame, transport error), tdata the start, data and reply
// fields. Results leave on m_axis: tuser is the kind (frame to send,
// finished, failed), tdata the frame identifier, eight frame bytes and the
// failure cause. cfg_we/cfg_wdata write the server node number.
// Each request is registered, then handled in one step of short compare and
// lane-insert logic that writes the result register, which drives m_axis.
// One request per cycle is taken as long as the result register drains; a
// request that produces no result (data byte mid-segment, good reply ack)
// still waits while a result is held on m_axis.
// When m_axis stalls with a result held, the input register fills and then
// s_axis_tready drops until the result is taken.
// Reset empties both registers, returns the transfer to idle and sets the
// node number to 1.
// ----------------------------------------------------------------------------
module sdo_segmented_download_client_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// object_index, object_subindex, total_size, data_byte, reply_id,
	// reply_command, reply_index, reply_subindex, zero pad
	input  logic [95:0] s_axis_tdata,
	// op
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// frame_id, frame_bytes, fail_cause, zero pad
	output logic [79:0] m_axis_tdata,
	// out_kind
	output logic [1:0]  m_axis_tuser
);

	logic [6:0]          node_id_q;
	logic                item_valid_s1;
	sdo_dl_pkg::item_t   item_s1;
	logic                out_valid_s2;
	sdo_dl_pkg::result_t out_s2;
	sdo_dl_pkg::result_t res;
	logic                step;

	assign step          = item_valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !item_valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			node_id_q <= 7'd1;
		else if (cfg_we)
			node_id_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			item_valid_s1 <= 1'b0;
		else if (s_axis_tready)
			item_valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.op              <= sdo_dl_pkg::op_t'(s_axis_tuser);
			item_s1.object_index    <= s_axis_tdata[15:0];
			item_s1.object_subindex <= s_axis_tdata[23:16];
			item_s1.total_size      <= s_axis_tdata[39:24];
			item_s1.data_byte       <= s_axis_tdata[47:40];
			item_s1.reply_id        <= s_axis_tdata[58:48];
			item_s1.reply_command   <= s_axis_tdata[66:59];
			item_s1.reply_index     <= s_axis_tdata[82:67];
			item_s1.reply_subindex  <= s_axis_tdata[90:83];
		end
	end

	sdo_dl_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item    (item_s1),
		.node_id (node_id_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_s2 <= 1'b0;
		else if (step)
			out_valid_s2 <= res.valid;
		else if (m_axis_tready)
			out_valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && res.valid)
			out_s2 <= res;
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tuser  = out_s2.kind;
	assign m_axis_tdata  = {2'b00, out_s2.cause, out_s2.frame_bytes, out_s2.frame_id};

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SDO segmented download client. Transfers are
// driven as request streams and every result is compared with a predictor
// that follows the client's phases, segment packing and reply checks.
// ----------------------------------------------------------------------------
module testbench;

	localparam int STALL_LIMIT  = 1000;
	localparam int SETTLE_TICKS = 6;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_INIT_WAIT,
		PH_GATHER,
		PH_SEG_WAIT
	} xfer_phase_t;

	// ways to break a transfer in progress
	typedef enum int {
		BAD_TRANSPORT,
		BAD_ID,
		BAD_INDEX,
		BAD_SUBINDEX,
		BAD_COMMAND,
		BAD_RESTART,
		BAD_WRONG_OP
	} fault_t;

	typedef struct packed {
		sdo_dl_pkg::kind_t  kind;
		logic [10:0]        frame_id;
		logic [63:0]        frame_bytes;
		sdo_dl_pkg::cause_t cause;
	} sdo_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [6:0]  cfg_wdata = 7'd0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	sdo_result_t expected_results[$];
	sdo_result_t head_result;
	int          mismatch_count = 0;
	bit          idle_enabled = 1'b1;
	int          long_hold_cycles = 0;

	// predicted client state
	xfer_phase_t xfer_phase = PH_IDLE;
	logic [6:0]  node_id = 7'd1;
	logic        toggle_bit = 1'b0;
	logic        last_segment = 1'b0;
	logic [15:0] bytes_left = '0;
	logic [55:0] seg_store = '0;
	logic [2:0]  seg_fill = '0;
	logic [15:0] saved_index = '0;
	logic [7:0]  saved_subindex = '0;

	sdo_segmented_download_client_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void clear_transfer();
		xfer_phase = PH_IDLE;
		toggle_bit = 1'b0;
		last_segment = 1'b0;
		bytes_left = '0;
		seg_store = '0;
		seg_fill = '0;
		saved_index = '0;
		saved_subindex = '0;
	endfunction

	// any result other than a frame ends the transfer
	function automatic void post_result(sdo_dl_pkg::kind_t kind, logic [63:0] bytes,
		sdo_dl_pkg::cause_t cause);
		sdo_result_t r;
		r.kind = kind;
		r.frame_id = (kind == sdo_dl_pkg::KIND_FRAME) ?
			sdo_dl_pkg::TX_BASE + 11'(node_id) : 11'd0;
		r.frame_bytes = (kind == sdo_dl_pkg::KIND_FRAME) ? bytes : 64'd0;
		r.cause = cause;
		expected_results.push_back(r);
		if (kind != sdo_dl_pkg::KIND_FRAME)
			clear_transfer();
	endfunction

	function automatic void predict_request(sdo_dl_pkg::item_t it);
		logic [10:0] rx_id;
		logic [7:0]  seg_cmd;
		rx_id = sdo_dl_pkg::RX_BASE + 11'(node_id);
		if (xfer_phase == PH_IDLE) begin
			if (it.op == sdo_dl_pkg::OP_START) begin
				clear_transfer();
				saved_index = it.object_index;
				saved_subindex = it.object_subindex;
				bytes_left = it.total_size;
				xfer_phase = PH_INIT_WAIT;
				post_result(sdo_dl_pkg::KIND_FRAME,
					{32'h0, it.object_subindex, it.object_index, sdo_dl_pkg::CMD_INITIATE},
					sdo_dl_pkg::CAUSE_NONE);
			end
		end else if (it.op == sdo_dl_pkg::OP_START) begin
			post_result(sdo_dl_pkg::KIND_FAIL, '0, sdo_dl_pkg::CAUSE_UNEXPECTED);
		end else if (it.op == sdo_dl_pkg::OP_ERROR) begin
			post_result(sdo_dl_pkg::KIND_FAIL, '0, sdo_dl_pkg::CAUSE_TRANSPORT);
		end else if (it.op == sdo_dl_pkg::OP_DATA) begin
			if (xfer_phase != PH_GATHER) begin
				post_result(sdo_dl_pkg::KIND_FAIL, '0, sdo_dl_pkg::CAUSE_UNEXPECTED);
			end else begin
				seg_store[8*seg_fill +: 8] = it.data_byte;
				seg_fill = seg_fill + 3'd1;
				bytes_left = bytes_left - 16'd1;
				if (seg_fill == sdo_dl_pkg::SEG_BYTES || bytes_left == 16'd0) begin
					last_segment = (bytes_left == 16'd0);
					seg_cmd = {3'b000, toggle_bit, sdo_dl_pkg::SEG_BYTES - seg_fill,
						last_segment};
					xfer_phase = PH_SEG_WAIT;
					post_result(sdo_dl_pkg::KIND_FRAME, {seg_store, seg_cmd},
						sdo_dl_pkg::CAUSE_NONE);
				end
			end
		end else if (xfer_phase == PH_GATHER) begin
			post_result(sdo_dl_pkg::KIND_FAIL, '0, sdo_dl_pkg::CAUSE_UNEXPECTED);
		end else if (it.reply_id != rx_id) begin
			post_result(sdo_dl_pkg::KIND_FAIL, '0, sdo_dl_pkg::CAUSE_REPLY_ID);
		end else if (xfer_phase == PH_INIT_WAIT) begin
			if (it.reply_index != saved_index)
				post_result(sdo_dl_pkg::KIND_FAIL, '0, sdo_dl_pkg::CAUSE_INDEX);
			else if (it.reply_subindex != saved_subindex)
				post_result(sdo_dl_pkg::KIND_FAIL, '0, sdo_dl_pkg::CAUSE_SUBINDEX);
			else if (it.reply_command != sdo_dl_pkg::CMD_INIT_ACK)
				post_result(sdo_dl_pkg::KIND_FAIL, '0, sdo_dl_pkg::CAUSE_COMMAND);
			else if (bytes_left == 16'd0)
				post_result(sdo_dl_pkg::KIND_DONE, '0, sdo_dl_pkg::CAUSE_NONE);
			else begin
				xfer_phase = PH_GATHER;
				seg_store = '0;
				seg_fill = '0;
			end
		end else if (it.reply_command != (sdo_dl_pkg::CMD_SEG_ACK |
			(toggle_bit ? sdo_dl_pkg::TOGGLE_MASK : 8'h00))) begin
			post_result(sdo_dl_pkg::KIND_FAIL, '0, sdo_dl_pkg::CAUSE_COMMAND);
		end else if (last_segment) begin
			post_result(sdo_dl_pkg::KIND_DONE, '0, sdo_dl_pkg::CAUSE_NONE);
		end else begin
			toggle_bit = ~toggle_bit;
			xfer_phase = PH_GATHER;
			seg_store = '0;
			seg_fill = '0;
		end
	endfunction

	function automatic sdo_dl_pkg::item_t random_item();
		sdo_dl_pkg::item_t it;
		it.op = sdo_dl_pkg::op_t'($urandom_range(0, 3));
		it.object_index = 16'($urandom);
		it.object_subindex = 8'($urandom);
		it.total_size = 16'($urandom);
		it.data_byte = 8'($urandom);
		it.reply_id = 11'($urandom);
		it.reply_command = 8'($urandom);
		it.reply_index = 16'($urandom);
		it.reply_subindex = 8'($urandom);
		return it;
	endfunction

	// reply the server would give in the current phase
	function automatic sdo_dl_pkg::item_t good_reply(sdo_dl_pkg::item_t it);
		it.op = sdo_dl_pkg::OP_REPLY;
		it.reply_id = sdo_dl_pkg::RX_BASE + 11'(node_id);
		if (xfer_phase == PH_INIT_WAIT) begin
			it.reply_command = sdo_dl_pkg::CMD_INIT_ACK;
			it.reply_index = saved_index;
			it.reply_subindex = saved_subindex;
		end else begin
			it.reply_command = sdo_dl_pkg::CMD_SEG_ACK |
				(toggle_bit ? sdo_dl_pkg::TOGGLE_MASK : 8'h00);
		end
		return it;
	endfunction

	function automatic sdo_dl_pkg::item_t fault_request(fault_t f);
		sdo_dl_pkg::item_t it;
		it = good_reply(random_item());
		case (f)
			BAD_TRANSPORT: it.op = sdo_dl_pkg::OP_ERROR;
			BAD_RESTART:   it.op = sdo_dl_pkg::OP_START;
			BAD_WRONG_OP:  it.op = (xfer_phase == PH_GATHER) ?
				sdo_dl_pkg::OP_REPLY : sdo_dl_pkg::OP_DATA;
			BAD_ID:        it.reply_id = it.reply_id ^ (11'd1 << $urandom_range(0, 10));
			BAD_INDEX:     it.reply_index = it.reply_index ^ (16'd1 << $urandom_range(0, 15));
			BAD_SUBINDEX:  it.reply_subindex = it.reply_subindex ^ (8'd1 << $urandom_range(0, 7));
			default:       it.reply_command = it.reply_command ^ (8'd1 << $urandom_range(0, 7));
		endcase
		return it;
	endfunction

	function automatic logic [15:0] pick_size();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 16'd0;
		if (r <= 3)
			return 16'(7 * $urandom_range(1, 4));
		if (r == 4)
			return 16'($urandom);
		return 16'($urandom_range(1, 40));
	endfunction

	// leaves tvalid high on return: the caller sends again or calls wait_drained
	task automatic send_request(input sdo_dl_pkg::item_t it);
		if (idle_enabled && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.op;
		s_axis_tdata <= {5'b0, it.reply_subindex, it.reply_index, it.reply_command,
			it.reply_id, it.data_byte, it.total_size, it.object_subindex, it.object_index};
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_request(it);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		// requests with no result may still be in the pipeline
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_node_id(input logic [6:0] id);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= id;
		@(posedge clk);
		cfg_we <= 1'b0;
		node_id = id;
	endtask

	task automatic test_idle_requests();
		sdo_dl_pkg::item_t it;
		it = random_item();
		it.op = sdo_dl_pkg::OP_DATA;
		send_request(it);
		it = random_item();
		it.op = sdo_dl_pkg::OP_REPLY;
		send_request(it);
		it = random_item();
		it.op = sdo_dl_pkg::OP_ERROR;
		send_request(it);
	endtask

	task automatic test_zero_length();
		sdo_dl_pkg::item_t it;
		it = random_item();
		it.op = sdo_dl_pkg::OP_START;
		it.object_index = 16'hFFFF;
		it.object_subindex = 8'hFF;
		it.total_size = 16'd0;
		send_request(it);
		send_request(good_reply(random_item()));
	endtask

	// one full segment then a one-byte last segment
	task automatic test_two_segments();
		sdo_dl_pkg::item_t it;
		it = random_item();
		it.op = sdo_dl_pkg::OP_START;
		it.object_index = 16'h0000;
		it.object_subindex = 8'h00;
		it.total_size = 16'd8;
		send_request(it);
		send_request(good_reply(random_item()));
		for (int k = 0; k < 8; k++) begin
			it = random_item();
			it.op = sdo_dl_pkg::OP_DATA;
			it.data_byte = (k == 0) ? 8'hFF : (k == 7) ? 8'h00 : 8'($urandom);
			send_request(it);
			if (xfer_phase == PH_SEG_WAIT)
				send_request(good_reply(random_item()));
		end
	endtask

	task automatic test_failure_causes();
		sdo_dl_pkg::item_t it;
		for (int v = BAD_TRANSPORT; v <= BAD_WRONG_OP; v++) begin
			it = random_item();
			it.op = sdo_dl_pkg::OP_START;
			send_request(it);
			send_request(fault_request(fault_t'(v)));
		end
	endtask

	task automatic test_backpressure();
		sdo_dl_pkg::item_t it;
		long_hold_cycles = 150;
		for (int k = 0; k < 24; k++) begin
			it = random_item();
			it.op = (xfer_phase == PH_IDLE) ? sdo_dl_pkg::OP_START : sdo_dl_pkg::OP_ERROR;
			send_request(it);
		end
		wait_drained();
	endtask

	task automatic test_random_transfers(input int request_count, input bit with_idling);
		sdo_dl_pkg::item_t it;
		int                sent;
		idle_enabled = with_idling;
		sent = 0;
		while (sent < request_count) begin
			it = random_item();
			if (xfer_phase == PH_IDLE) begin
				if ($urandom_range(0, 9) == 0) begin
					// ignored while idle, not counted
					it.op = sdo_dl_pkg::op_t'($urandom_range(1, 3));
					send_request(it);
					continue;
				end
				it.op = sdo_dl_pkg::OP_START;
				it.total_size = pick_size();
			end else if ($urandom_range(0, 39) == 0) begin
				it = fault_request(fault_t'($urandom_range(BAD_TRANSPORT, BAD_WRONG_OP)));
			end else if (xfer_phase == PH_GATHER) begin
				it.op = sdo_dl_pkg::OP_DATA;
			end else begin
				it = good_reply(it);
			end
			send_request(it);
			sent++;
		end
		if (xfer_phase != PH_IDLE)
			send_request(fault_request(BAD_TRANSPORT));
		wait_drained();
	endtask

	// receiver: random ready bursts, plus one long hold on request
	initial begin
		forever begin
			if (long_hold_cycles != 0) begin
				m_axis_tready <= 1'b0;
				repeat (long_hold_cycles) @(posedge clk);
				long_hold_cycles = 0;
			end else if (idle_enabled && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual kind %0d tdata %h",
					$time, m_axis_tuser, m_axis_tdata);
				mismatch_count++;
			end else begin
				head_result = expected_results.pop_front();
				if (m_axis_tuser != head_result.kind) begin
					$display("%0t: out_kind mismatch: expected %0d actual %0d",
						$time, head_result.kind, m_axis_tuser);
					mismatch_count++;
				end
				if (m_axis_tdata[10:0] != head_result.frame_id) begin
					$display("%0t: frame_id mismatch: expected %h actual %h",
						$time, head_result.frame_id, m_axis_tdata[10:0]);
					mismatch_count++;
				end
				if (m_axis_tdata[74:11] != head_result.frame_bytes) begin
					$display("%0t: frame_bytes mismatch: expected %h actual %h",
						$time, head_result.frame_bytes, m_axis_tdata[74:11]);
					mismatch_count++;
				end
				if (m_axis_tdata[77:75] != head_result.cause) begin
					$display("%0t: fail_cause mismatch: expected %0d actual %0d",
						$time, head_result.cause, m_axis_tdata[77:75]);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog: cycles with no transfer on either stream
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		clear_transfer();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_idle_requests();
		test_zero_length();
		test_two_segments();
		test_failure_causes();
		write_node_id(7'd127);
		test_backpressure();
		test_random_transfers(320, 1'b1);
		write_node_id(7'($urandom_range(2, 126)));
		test_random_transfers(320, 1'b1);
		write_node_id(7'd1);
		test_random_transfers(280, 1'b1);
		test_random_transfers(100, 1'b0);

		wait_drained();
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
design/sdo_dl_pkg.sv
design/sdo_dl_engine.sv
design/sdo_segmented_download_client_core.sv
test/testbench.sv
